FILE: hdl/mag_hard_iron_calibrator_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the hard-iron calibrator
// Concurrent checks clocked on the rising edge, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef MAG_HARD_IRON_CALIBRATOR_DEFINES_SVH
`define MAG_HARD_IRON_CALIBRATOR_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication check
`define MHIC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mhic assertion failed");
// Next-cycle implication check
`define MHIC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mhic assertion failed");
`else
`define MHIC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define MHIC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: hdl/mhic_pkg.sv
// ----------------------------------------------------------------------------
// mhic_pkg
// Types, widths and register codes shared by the hard-iron calibrator.
// ----------------------------------------------------------------------------
package mhic_pkg;

  // Sample and result widths
  localparam int SAMPLE_BITS = 16;
  localparam int OFF_W       = 16;
  localparam int SPAN_W      = 15;
  localparam int CNT_W       = 16;
  localparam int THR_W       = 18;
  localparam int ABS_W       = SAMPLE_BITS + 1;
  localparam int DELTA_W     = SAMPLE_BITS + 3;
  localparam int CMP_W       = (DELTA_W > THR_W) ? DELTA_W : THR_W;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 18;

  localparam logic [CNT_W-1:0] TARGET_RST = CNT_W'(1000);
  localparam logic [THR_W-1:0] THRESH_RST = THR_W'(1);
  localparam logic [CNT_W-1:0] LIMIT_RST  = CNT_W'(50);
  localparam logic [CNT_W-1:0] CNT_MAX    = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLE_TARGET   = 2'd0,
    CFG_STILL_THRESHOLD = 2'd1,
    CFG_STILL_LIMIT     = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    CMD_SEED  = 1'b0,
    CMD_ACCUM = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t                          cmd;
    logic signed [SAMPLE_BITS-1:0] sample_x;
    logic signed [SAMPLE_BITS-1:0] sample_y;
    logic signed [SAMPLE_BITS-1:0] sample_z;
  } in_t;

  typedef struct packed {
    logic signed [OFF_W-1:0] offset_x;
    logic signed [OFF_W-1:0] offset_y;
    logic signed [OFF_W-1:0] offset_z;
    logic [SPAN_W-1:0]       half_span_x;
    logic [SPAN_W-1:0]       half_span_y;
    logic [SPAN_W-1:0]       half_span_z;
    logic                    static_warning;
    logic [CNT_W-1:0]        samples_taken;
    logic                    run_done;
  } out_t;

  typedef struct packed {
    logic [CNT_W-1:0] sample_target;
    logic [THR_W-1:0] still_threshold;
    logic [CNT_W-1:0] still_limit;
  } cfg_t;

  typedef struct packed {
    logic seed;
    logic accum;
  } axis_ctl_t;

endpackage

FILE: hdl/mag_hard_iron_calibrator.sv
// A result passes through the input register and then the output register, which holds
// it with out_valid high until out_ready. Throughput: one sample per cycle while
// out_ready is high; the min/max, stillness and sample counters update in the single
// processing stage between the input and output registers. A stalled result holds the
// item in the input register; in_ready is high then only while that register is empty.
// Reset (synchronous, rst_n low) clears or presets all state but the two data registers.
// ----------------------------------------------------------------------------
// mag_hard_iron_calibrator
// Three-axis hard-iron min/max calibration with a stillness warning.
// ----------------------------------------------------------------------------
`include "mag_hard_iron_calibrator_defines.svh"

module mag_hard_iron_calibrator (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  mhic_pkg::in_t                   in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output mhic_pkg::out_t                  out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mhic_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mhic_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mhic_pkg::*;

  cfg_t             cfg;
  logic             s1_valid_r;
  in_t              s1_data_r;
  logic             adv;
  axis_ctl_t        ctl;
  logic             seed;
  logic [ABS_W-1:0] abs_x, abs_y, abs_z;
  logic [DELTA_W-1:0] delta;
  logic             still;
  logic [CNT_W-1:0] still_cnt_r, still_cnt_nxt;
  logic             warned_r, warned_nxt;
  logic [CNT_W-1:0] sample_cnt_r, sample_cnt_nxt;
  logic             done_r, done_nxt;
  logic             warn;
  out_t             result;
  logic             out_valid_r;
  out_t             out_data_r;

  mhic_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Advance the processing stage when it holds an item and the output register is free or transferring
  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || adv;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data_r <= in_data;
    end
  end

  // Per-axis control
  assign seed      = adv && (s1_data_r.cmd == CMD_SEED);
  assign ctl.seed  = seed;
  assign ctl.accum = adv && (s1_data_r.cmd == CMD_ACCUM) && !done_r;

  mhic_axis u_axis_x (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .sample    (s1_data_r.sample_x),
    .abs_delta (abs_x),
    .offset    (result.offset_x),
    .half_span (result.half_span_x)
  );

  mhic_axis u_axis_y (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .sample    (s1_data_r.sample_y),
    .abs_delta (abs_y),
    .offset    (result.offset_y),
    .half_span (result.half_span_y)
  );

  mhic_axis u_axis_z (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .sample    (s1_data_r.sample_z),
    .abs_delta (abs_z),
    .offset    (result.offset_z),
    .half_span (result.half_span_z)
  );

  // Summed absolute change against the threshold
  assign delta = DELTA_W'(abs_x) + DELTA_W'(abs_y) + DELTA_W'(abs_z);
  assign still = CMP_W'(delta) < CMP_W'(cfg.still_threshold);

  // Stillness, warning and sample counters
  always_comb begin
    still_cnt_nxt  = still_cnt_r;
    warned_nxt     = warned_r;
    sample_cnt_nxt = sample_cnt_r;
    done_nxt       = done_r;
    warn           = 1'b0;
    if (ctl.seed) begin
      still_cnt_nxt  = '0;
      warned_nxt     = 1'b0;
      sample_cnt_nxt = '0;
      done_nxt       = 1'b0;
    end else if (ctl.accum) begin
      if (still) begin
        if (still_cnt_r != CNT_MAX) still_cnt_nxt = still_cnt_r + 1'b1;
      end else begin
        still_cnt_nxt = '0;
        warned_nxt    = 1'b0;
      end
      if ((still_cnt_nxt > cfg.still_limit) && !warned_nxt) begin
        warn       = 1'b1;
        warned_nxt = 1'b1;
      end
      if (sample_cnt_r != CNT_MAX) sample_cnt_nxt = sample_cnt_r + 1'b1;
      if (sample_cnt_nxt >= cfg.sample_target) done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      still_cnt_r  <= '0;
      warned_r     <= 1'b0;
      sample_cnt_r <= '0;
      done_r       <= 1'b0;
    end else begin
      still_cnt_r  <= still_cnt_nxt;
      warned_r     <= warned_nxt;
      sample_cnt_r <= sample_cnt_nxt;
      done_r       <= done_nxt;
    end
  end

  assign result.static_warning = warn;
  assign result.samples_taken  = sample_cnt_nxt;
  assign result.run_done       = done_nxt;

  // Output register: load on advance, drop after transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A seed reports an empty run
  `MHIC_ASSERT_NEXT(a_seed_result, clk, rst_n, seed,
    out_valid_r && out_data_r.samples_taken == '0 && !out_data_r.run_done &&
    !out_data_r.static_warning && out_data_r.half_span_x == '0 &&
    out_data_r.half_span_y == '0 && out_data_r.half_span_z == '0)
  // A finished run stops counting until the next seed
  `MHIC_ASSERT_NEXT(a_done_holds, clk, rst_n, done_r && !seed, done_r && $stable(sample_cnt_r))
  // A pending warning result matches the armed flag
  `MHIC_ASSERT_IMPL(a_warn_flag, clk, rst_n, out_valid_r && out_data_r.static_warning, warned_r)
  // A stalled input item is never dropped
  `MHIC_ASSERT_NEXT(a_s1_kept, clk, rst_n, s1_valid_r && !adv, s1_valid_r)

endmodule

FILE: hdl/mhic_cfg_regs.sv
// ----------------------------------------------------------------------------
// mhic_cfg_regs
// Configuration register file: target, stillness threshold and limit.
// ----------------------------------------------------------------------------
module mhic_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mhic_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mhic_pkg::CFG_DATA_W-1:0] cfg_data,
  output mhic_pkg::cfg_t                  cfg
);
  import mhic_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Always take a write transfer
  assign cfg_ready = 1'b1;

  // Decode the register index
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SAMPLE_TARGET:   cfg_nxt.sample_target   = cfg_data[CNT_W-1:0];
        CFG_STILL_THRESHOLD: cfg_nxt.still_threshold = cfg_data[THR_W-1:0];
        CFG_STILL_LIMIT:     cfg_nxt.still_limit     = cfg_data[CNT_W-1:0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sample_target   <= TARGET_RST;
      cfg_r.still_threshold <= THRESH_RST;
      cfg_r.still_limit     <= LIMIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: hdl/mhic_axis.sv
// ----------------------------------------------------------------------------
// mhic_axis
// One axis: running min, max and previous sample, offset and half span.
// ----------------------------------------------------------------------------
module mhic_axis (
  input  logic                                clk,
  input  logic                                rst_n,
  input  mhic_pkg::axis_ctl_t                 ctl,
  input  logic signed [mhic_pkg::SAMPLE_BITS-1:0] sample,
  output logic [mhic_pkg::ABS_W-1:0]          abs_delta,
  output logic signed [mhic_pkg::OFF_W-1:0]   offset,
  output logic [mhic_pkg::SPAN_W-1:0]         half_span
);
  import mhic_pkg::*;

  localparam int SW = SAMPLE_BITS;
  localparam int EW = (SW > OFF_W) ? SW : OFF_W;
  localparam int HW = (SW > SPAN_W) ? SW : SPAN_W;
  localparam logic signed [EW-1:0] OFF_MAX_E = EW'(32767);
  localparam logic signed [EW-1:0] OFF_MIN_E = EW'(-32768);
  localparam logic [HW-1:0]        SPAN_MAX_E = HW'(32767);

  logic signed [SW-1:0] min_r, min_nxt;
  logic signed [SW-1:0] max_r, max_nxt;
  logic signed [SW-1:0] last_r;
  logic signed [SW:0]   diff;
  logic signed [SW:0]   sum;
  logic signed [SW:0]   range;
  logic signed [SW-1:0] mid;
  logic signed [EW-1:0] mid_ext;
  logic [HW-1:0]        hs_ext;

  // Change from the previous sample
  assign diff      = (SW+1)'(sample) - (SW+1)'(last_r);
  assign abs_delta = diff[SW] ? ABS_W'(-diff) : ABS_W'(diff);

  // Seed or widen the running extremes
  always_comb begin
    min_nxt = min_r;
    max_nxt = max_r;
    if (ctl.seed) begin
      min_nxt = sample;
      max_nxt = sample;
    end else if (ctl.accum) begin
      if (sample < min_r) min_nxt = sample;
      if (sample > max_r) max_nxt = sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r  <= '0;
      max_r  <= '0;
      last_r <= '0;
    end else if (ctl.seed || ctl.accum) begin
      min_r  <= min_nxt;
      max_r  <= max_nxt;
      last_r <= sample;
    end
  end

  // Midpoint by arithmetic shift, clamped to the offset width
  assign sum     = (SW+1)'(max_nxt) + (SW+1)'(min_nxt);
  assign mid     = sum[SW:1];
  assign mid_ext = EW'(mid);

  always_comb begin
    if (mid_ext > OFF_MAX_E) begin
      offset = OFF_MAX_E[OFF_W-1:0];
    end else if (mid_ext < OFF_MIN_E) begin
      offset = OFF_MIN_E[OFF_W-1:0];
    end else begin
      offset = mid_ext[OFF_W-1:0];
    end
  end

  // Half range, clamped to the span width
  assign range  = (SW+1)'(max_nxt) - (SW+1)'(min_nxt);
  assign hs_ext = HW'(range[SW:1]);

  always_comb begin
    if (hs_ext > SPAN_MAX_E) begin
      half_span = SPAN_MAX_E[SPAN_W-1:0];
    end else begin
      half_span = hs_ext[SPAN_W-1:0];
    end
  end

endmodule
